/* rtl/dtseq_pkg.sv */
// ----------------------------------------------------------------------------
// dtseq_pkg
// Shared types and constants for the detection debounce and task sequencer.
// ----------------------------------------------------------------------------
package dtseq_pkg;

  // Configuration port geometry
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Stream payload widths
  localparam int IN_TDATA_W  = 8;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_FRAMES     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN_FRAMES = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIM_ARM_EN      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ARM_TICKS       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COMMAND_ENABLE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_CODE       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RESUME_CODE     = 3'd6;

  // Register reset values
  localparam logic [7:0]  RST_HOLD_FRAMES     = 8'd3;
  localparam logic [7:0]  RST_COOLDOWN_FRAMES = 8'd5;
  localparam logic        RST_SIM_ARM_EN      = 1'b0;
  localparam logic [15:0] RST_ARM_TICKS       = 16'd30;
  localparam logic        RST_COMMAND_ENABLE  = 1'b0;
  localparam logic [7:0]  RST_STOP_CODE       = 8'd2;
  localparam logic [7:0]  RST_RESUME_CODE     = 8'd1;

  // Item kinds carried on in_tuser
  localparam logic [1:0] OP_FRAME    = 2'd0;
  localparam logic [1:0] OP_ARM_DONE = 2'd1;
  localparam logic [1:0] OP_TICK     = 2'd2;
  localparam logic [1:0] OP_RESERVED = 2'd3;

  // Task phase
  typedef enum logic [1:0] {
    PH_RUNNING  = 2'd0,
    PH_ARM      = 2'd1,
    PH_COOLDOWN = 2'd2
  } phase_t;

  // Configuration register set
  typedef struct packed {
    logic [7:0]  hold_frames;
    logic [7:0]  cooldown_frames;
    logic        sim_arm_en;
    logic [15:0] arm_duration_ticks;
    logic        command_enable;
    logic [7:0]  stop_code;
    logic [7:0]  resume_code;
  } cfg_t;

  // One input item
  typedef struct packed {
    logic [1:0] op;
    logic       frame_detected;
    logic       done_flag;
  } item_t;

  // One result item
  typedef struct packed {
    logic       latched_out;
    phase_t     task_phase;
    logic [7:0] command_code;
    logic       command_valid;
    logic       resume_event;
    logic       stop_event;
  } res_t;

endpackage

/* rtl/dtseq_cfg.sv */
// ----------------------------------------------------------------------------
// dtseq_cfg
// Configuration register file, write only, indexed writes.
// ----------------------------------------------------------------------------
module dtseq_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [dtseq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dtseq_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output dtseq_pkg::cfg_t                 cfg
);
  import dtseq_pkg::*;

  cfg_t cfg_r;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hold_frames        <= RST_HOLD_FRAMES;
      cfg_r.cooldown_frames    <= RST_COOLDOWN_FRAMES;
      cfg_r.sim_arm_en         <= RST_SIM_ARM_EN;
      cfg_r.arm_duration_ticks <= RST_ARM_TICKS;
      cfg_r.command_enable     <= RST_COMMAND_ENABLE;
      cfg_r.stop_code          <= RST_STOP_CODE;
      cfg_r.resume_code        <= RST_RESUME_CODE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HOLD_FRAMES:     cfg_r.hold_frames        <= cfg_wdata[7:0];
        REG_COOLDOWN_FRAMES: cfg_r.cooldown_frames    <= cfg_wdata[7:0];
        REG_SIM_ARM_EN:      cfg_r.sim_arm_en         <= cfg_wdata[0];
        REG_ARM_TICKS:       cfg_r.arm_duration_ticks <= cfg_wdata[15:0];
        REG_COMMAND_ENABLE:  cfg_r.command_enable     <= cfg_wdata[0];
        REG_STOP_CODE:       cfg_r.stop_code          <= cfg_wdata[7:0];
        REG_RESUME_CODE:     cfg_r.resume_code        <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

/* rtl/dtseq_core.sv */
// ----------------------------------------------------------------------------
// dtseq_core
// Input register, sequencer state and the single-pass step logic.
// ----------------------------------------------------------------------------
module dtseq_core (
  input  logic             clk,
  input  logic             rst_n,
  input  dtseq_pkg::cfg_t  cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  dtseq_pkg::item_t in_item,
  input  logic             res_ready,
  output logic             res_load,
  output dtseq_pkg::res_t  res
);
  import dtseq_pkg::*;

  // Input stage
  logic   s1_valid_r;
  item_t  s1_item_r;

  // Sequencer state
  phase_t      phase_r, phase_nxt;
  logic [7:0]  hit_r, hit_nxt;
  logic [7:0]  miss_r, miss_nxt;
  logic        latch_r, latch_nxt;
  logic        busy_r, busy_nxt;
  logic [15:0] ticks_r, ticks_nxt;

  // Step flags and effective thresholds
  logic       stop_hit;
  logic       complete;
  logic [7:0] hold_eff;
  logic [7:0] rel_eff;
  logic [8:0] hit_inc;
  logic [8:0] miss_inc;

  assign res_load = s1_valid_r & res_ready;
  assign in_ready = ~s1_valid_r | res_ready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_item;
    end
  end

  // State commits when the item moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_RUNNING;
      hit_r   <= 8'd0;
      miss_r  <= 8'd0;
      latch_r <= 1'b0;
      busy_r  <= 1'b0;
      ticks_r <= 16'd0;
    end else if (res_load) begin
      phase_r <= phase_nxt;
      hit_r   <= hit_nxt;
      miss_r  <= miss_nxt;
      latch_r <= latch_nxt;
      busy_r  <= busy_nxt;
      ticks_r <= ticks_nxt;
    end
  end

  // Effective thresholds: hold at least 1, release at least hold
  always_comb begin
    hold_eff = (cfg.hold_frames == 8'd0) ? 8'd1 : cfg.hold_frames;
    rel_eff  = (cfg.cooldown_frames < hold_eff) ? hold_eff : cfg.cooldown_frames;
    hit_inc  = {1'b0, hit_r} + 9'd1;
    miss_inc = {1'b0, miss_r} + 9'd1;
  end

  // Next state
  always_comb begin
    phase_nxt = phase_r;
    hit_nxt   = hit_r;
    miss_nxt  = miss_r;
    latch_nxt = latch_r;
    busy_nxt  = busy_r;
    ticks_nxt = ticks_r;
    stop_hit  = 1'b0;
    complete  = 1'b0;

    case (s1_item_r.op)
      OP_FRAME: begin
        // saturating hit / miss counters
        if (s1_item_r.frame_detected) begin
          hit_nxt  = (hit_inc < {1'b0, hold_eff}) ? hit_inc[7:0] : hold_eff;
          miss_nxt = 8'd0;
        end else begin
          miss_nxt = (miss_inc < {1'b0, rel_eff}) ? miss_inc[7:0] : rel_eff;
          hit_nxt  = 8'd0;
        end
        // cooldown ends after enough misses
        if (phase_r == PH_COOLDOWN && miss_nxt >= rel_eff) begin
          phase_nxt = PH_RUNNING;
          latch_nxt = 1'b0;
          hit_nxt   = 8'd0;
          miss_nxt  = 8'd0;
        end
        // debounced detection triggers a stop
        if (!latch_nxt && phase_nxt == PH_RUNNING && s1_item_r.frame_detected &&
            hit_nxt >= hold_eff) begin
          latch_nxt = 1'b1;
          phase_nxt = PH_ARM;
          busy_nxt  = 1'b1;
          ticks_nxt = cfg.arm_duration_ticks;
          stop_hit  = 1'b1;
        end
      end
      OP_ARM_DONE: begin
        complete = s1_item_r.done_flag & busy_r;
      end
      OP_TICK: begin
        if (cfg.sim_arm_en && busy_r) begin
          ticks_nxt = (ticks_r != 16'd0) ? ticks_r - 16'd1 : ticks_r;
          complete  = (ticks_nxt == 16'd0);
        end
      end
      default: ;
    endcase

    // arm phase completion
    if (complete) begin
      busy_nxt  = 1'b0;
      phase_nxt = PH_COOLDOWN;
      miss_nxt  = 8'd0;
    end
  end

  // Result fields
  always_comb begin
    res.stop_event    = stop_hit;
    res.resume_event  = complete;
    res.command_valid = cfg.command_enable & (stop_hit | complete);
    res.command_code  = 8'd0;
    if (cfg.command_enable) begin
      if (stop_hit) begin
        res.command_code = cfg.stop_code;
      end else if (complete) begin
        res.command_code = cfg.resume_code;
      end
    end
    res.task_phase  = phase_nxt;
    res.latched_out = latch_nxt;
  end

endmodule

/* rtl/dtseq_out.sv */
// ----------------------------------------------------------------------------
// dtseq_out
// Result register toward the output stream.
// ----------------------------------------------------------------------------
module dtseq_out (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            res_load,
  input  dtseq_pkg::res_t res,
  output logic            res_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output dtseq_pkg::res_t out_res
);
  import dtseq_pkg::*;

  logic out_valid_r;
  res_t out_res_r;

  // Free when empty or when the held beat leaves this cycle
  assign res_ready = ~out_valid_r | out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_load;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_res_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

/* rtl/detection_debounce_task_sequencer.sv */
// ----------------------------------------------------------------------------
// detection_debounce_task_sequencer
// Path: input register, step logic, then result register driving out_*.
// Throughput: one item per cycle, set by the input and result registers
// around a single pass of step logic; stalls only under out_tready backpressure.
// Reset (rst_n low, synchronous): phase running, counters, latch and countdown
// cleared, registers at their defaults, both streams empty.
// ----------------------------------------------------------------------------
module detection_debounce_task_sequencer (
  input  logic                             clk,
  input  logic                             rst_n,
  // input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [dtseq_pkg::IN_TDATA_W-1:0]  in_tdata,  // [0] frame_detected, [1] done_flag
  input  logic [dtseq_pkg::IN_TUSER_W-1:0]  in_tuser,  // [1:0] op
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [0] stop_event, [1] resume_event, [2] command_valid, [10:3] command_code,
  // [12:11] task_phase, [13] latched_out
  output logic [dtseq_pkg::OUT_TDATA_W-1:0] out_tdata,
  // configuration
  input  logic                             cfg_we,
  input  logic [dtseq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dtseq_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import dtseq_pkg::*;

  cfg_t  cfg;
  item_t in_item;
  res_t  res;
  res_t  out_res;
  logic  res_load;
  logic  res_ready;

  // Unpack input beat
  always_comb begin
    in_item.op             = in_tuser;
    in_item.frame_detected = in_tdata[0];
    in_item.done_flag      = in_tdata[1];
  end

  dtseq_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  dtseq_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_item   (in_item),
    .res_ready (res_ready),
    .res_load  (res_load),
    .res       (res)
  );

  dtseq_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_load  (res_load),
    .res       (res),
    .res_ready (res_ready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  // Pack result beat
  assign out_tdata = {2'b00, out_res.latched_out, out_res.task_phase,
                      out_res.command_code, out_res.command_valid,
                      out_res.resume_event, out_res.stop_event};

endmodule

/* rtl/dtseq_checker.sv */
// ----------------------------------------------------------------------------
// dtseq_checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module dtseq_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [dtseq_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import dtseq_pkg::*;

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // Stop and resume never come from the same item
  a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[1]))
    else $error("stop and resume in one beat");

  // A command goes out only with a stop or a resume
  a_cmd_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2] |-> (out_tdata[0] || out_tdata[1]))
    else $error("command without event");

  // Without a command the code reads zero
  a_cmd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[2] |-> out_tdata[10:3] == 8'd0)
    else $error("command code nonzero without command");

  // A stop leaves the block latched in the arm phase
  a_stop_arm: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[12:11] == PH_ARM && out_tdata[13])
    else $error("stop without arm phase and latch");

endmodule

bind detection_debounce_task_sequencer dtseq_checker u_dtseq_checker (.*);

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: detection debounce and task sequencer
// Drives frame, arm-done and tick beats into the sequencer under several
// register settings, predicts every result beat from a local model of the
// debounce counters and phase machine, and checks each result field by field.
// ----------------------------------------------------------------------------
module tb;
  import dtseq_pkg::*;

  localparam int STALL_LIMIT = 3000;

  logic                   clk;
  logic                   rst_n     = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata  = '0;  // [0] frame_detected, [1] done_flag
  logic [IN_TUSER_W-1:0]  in_tuser  = '0;  // [1:0] op
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // [0] stop_event, [1] resume_event, [2] command_valid, [10:3] command_code,
  // [12:11] task_phase, [13] latched_out
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  detection_debounce_task_sequencer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // pending stimulus and expected results
  item_t pend_items[$];
  res_t  expected_results[$];

  int in_put     = 0;
  int in_acc     = 0;
  int out_cnt    = 0;
  int errors     = 0;
  int stops_seen = 0;
  int resumes_seen = 0;
  int stall_cnt  = 0;
  int gen_used   = 0;

  // register shadow, starts at reset defaults
  cfg_t shadow = '{hold_frames: RST_HOLD_FRAMES, cooldown_frames: RST_COOLDOWN_FRAMES,
                   sim_arm_en: RST_SIM_ARM_EN, arm_duration_ticks: RST_ARM_TICKS,
                   command_enable: RST_COMMAND_ENABLE, stop_code: RST_STOP_CODE,
                   resume_code: RST_RESUME_CODE};

  // sequencer state as predicted
  phase_t      seq_phase  = PH_RUNNING;
  int unsigned hit_run    = 0;
  int unsigned miss_run   = 0;
  logic        det_latch  = 1'b0;
  logic        arm_busy   = 1'b0;
  logic [15:0] ticks_left = '0;

  // Next-state and result for one accepted item
  function automatic res_t advance_sequencer(logic [1:0] op, logic det, logic done);
    res_t        r;
    int unsigned h;
    int unsigned rel;
    bit          complete;
    r        = '0;
    complete = 1'b0;
    h   = (shadow.hold_frames == 0) ? 1 : shadow.hold_frames;
    rel = (shadow.cooldown_frames < h) ? h : shadow.cooldown_frames;
    case (op)
      OP_FRAME: begin
        if (det) begin
          hit_run  = (hit_run + 1 < h) ? hit_run + 1 : h;
          miss_run = 0;
        end else begin
          miss_run = (miss_run + 1 < rel) ? miss_run + 1 : rel;
          hit_run  = 0;
        end
        // enough misses in cooldown re-arm the detector
        if (seq_phase == PH_COOLDOWN && miss_run >= rel) begin
          seq_phase = PH_RUNNING;
          det_latch = 1'b0;
          hit_run   = 0;
          miss_run  = 0;
        end
        if (!det_latch && seq_phase == PH_RUNNING && det && hit_run >= h) begin
          det_latch    = 1'b1;
          seq_phase    = PH_ARM;
          arm_busy     = 1'b1;
          ticks_left   = shadow.arm_duration_ticks;
          r.stop_event = 1'b1;
          if (shadow.command_enable) begin
            r.command_valid = 1'b1;
            r.command_code  = shadow.stop_code;
          end
        end
      end
      OP_ARM_DONE: complete = done && arm_busy;
      OP_TICK: begin
        if (shadow.sim_arm_en && arm_busy) begin
          if (ticks_left > 0) ticks_left = ticks_left - 16'd1;
          complete = (ticks_left == 0);
        end
      end
      default: ;
    endcase
    if (complete) begin
      arm_busy       = 1'b0;
      seq_phase      = PH_COOLDOWN;
      miss_run       = 0;
      r.resume_event = 1'b1;
      if (shadow.command_enable) begin
        r.command_valid = 1'b1;
        r.command_code  = shadow.resume_code;
      end
    end
    r.task_phase  = seq_phase;
    r.latched_out = det_latch;
    return r;
  endfunction

  // idle percentage by progress: sender light first, then receiver light, then none
  function automatic int idle_pct(bit sender, int n);
    if (n < 330) return sender ? 22 : 69;
    if (n < 660) return sender ? 69 : 22;
    return 0;
  endfunction

  // random single bit
  function automatic logic coin();
    return 1'($urandom_range(0, 1));
  endfunction

  // input driver: hold the beat until accepted, else maybe put up the next one
  always @(negedge clk) begin : drive_input
    item_t nxt;
    logic  nvalid;
    nvalid = in_tvalid;
    if (rst_n && !(in_tvalid && in_acc < in_put)) begin
      nvalid = 1'b0;
      if (pend_items.size() > 0 && $urandom_range(0, 99) >= idle_pct(1'b1, in_acc)) begin
        nxt       = pend_items.pop_front();
        in_tdata  <= {6'b0, nxt.done_flag, nxt.frame_detected};
        in_tuser  <= nxt.op;
        nvalid    = 1'b1;
        in_put    = in_put + 1;
      end
    end
    in_tvalid <= nvalid;
  end

  // receiver backpressure
  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= idle_pct(1'b0, in_acc));
  end

  // predict on every accepted input beat
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      expected_results.push_back(advance_sequencer(in_tuser, in_tdata[0], in_tdata[1]));
      in_acc = in_acc + 1;
    end
  end

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors = errors + 1;
    end
  endtask

  // result monitor
  always @(posedge clk) begin : check_output
    res_t got;
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = res_t'(out_tdata[13:0]);
      if (expected_results.size() == 0) begin
        $error("result beat with no expected result: tdata %h", out_tdata);
        errors = errors + 1;
      end else begin
        want = expected_results.pop_front();
        check_field("stop_event", want.stop_event, got.stop_event);
        check_field("resume_event", want.resume_event, got.resume_event);
        check_field("command_valid", want.command_valid, got.command_valid);
        check_field("command_code", want.command_code, got.command_code);
        check_field("task_phase", int'(want.task_phase), int'(got.task_phase));
        check_field("latched_out", want.latched_out, got.latched_out);
        if (want.stop_event) stops_seen = stops_seen + 1;
        if (want.resume_event) resumes_seen = resumes_seen + 1;
      end
      out_cnt = out_cnt + 1;
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cnt = 0;
    end else begin
      stall_cnt = stall_cnt + 1;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  function automatic void push_item(logic [1:0] op, logic det, logic done, bit counts);
    pend_items.push_back('{op, det, done});
    if (counts) gen_used = gen_used + 1;
  endfunction

  // occasional beat that changes nothing
  function automatic void maybe_noise();
    int pick;
    if ($urandom_range(0, 7) != 0) return;
    pick = $urandom_range(0, 2);
    if (pick == 0)
      push_item(OP_RESERVED, coin(), coin(), 1'b0);
    else if (pick == 1 || shadow.sim_arm_en)
      push_item(OP_ARM_DONE, coin(), 1'b0, 1'b0);
    else
      push_item(OP_TICK, coin(), coin(), 1'b0);
  endfunction

  // Episodes: hit run -> arm completion -> miss run, with noise and broken runs
  task automatic gen_segment(int budget);
    int h;
    int rel;
    int n;
    int brk;
    int i;
    gen_used = 0;
    h   = (shadow.hold_frames == 0) ? 1 : shadow.hold_frames;
    rel = (shadow.cooldown_frames < h) ? h : shadow.cooldown_frames;
    while (gen_used < budget) begin
      // detection run, one in five broken by a miss
      n   = h + $urandom_range(0, 2);
      brk = ($urandom_range(0, 4) == 0) ? $urandom_range(0, n - 1) : -1;
      for (i = 0; i < n && gen_used < budget; i++) begin
        push_item(OP_FRAME, (i != brk), coin(), 1'b1);
        maybe_noise();
      end
      // frames during the arm phase, then completion
      repeat ($urandom_range(0, 2))
        push_item(OP_FRAME, coin(), coin(), 1'b1);
      if (shadow.sim_arm_en && $urandom_range(0, 3) != 0) begin
        n = (shadow.arm_duration_ticks < 6) ?
            shadow.arm_duration_ticks + $urandom_range(0, 1) : $urandom_range(1, 4);
        if (n == 0) n = 1;
        repeat (n) begin
          push_item(OP_TICK, coin(), coin(), 1'b1);
          maybe_noise();
        end
        if (shadow.arm_duration_ticks >= 6)
          push_item(OP_ARM_DONE, coin(), 1'b1, 1'b1);
      end else begin
        maybe_noise();
        push_item(OP_ARM_DONE, coin(), 1'b1, 1'b1);
      end
      // cooldown miss run, sometimes broken by a hit
      n   = rel + $urandom_range(0, 2);
      brk = ($urandom_range(0, 4) == 0) ? $urandom_range(0, n - 1) : -1;
      for (i = 0; i < n && gen_used < budget; i++) begin
        push_item(OP_FRAME, (i == brk), coin(), 1'b1);
        maybe_noise();
      end
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_HOLD_FRAMES:     shadow.hold_frames        = val[7:0];
      REG_COOLDOWN_FRAMES: shadow.cooldown_frames    = val[7:0];
      REG_SIM_ARM_EN:      shadow.sim_arm_en         = val[0];
      REG_ARM_TICKS:       shadow.arm_duration_ticks = val;
      REG_COMMAND_ENABLE:  shadow.command_enable     = val[0];
      REG_STOP_CODE:       shadow.stop_code          = val[7:0];
      REG_RESUME_CODE:     shadow.resume_code        = val[7:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(logic [7:0] h, logic [7:0] r, logic sim, logic [15:0] t,
                                logic cen, logic [7:0] sc, logic [7:0] rc);
    write_reg(REG_HOLD_FRAMES, 16'(h));
    write_reg(REG_COOLDOWN_FRAMES, 16'(r));
    write_reg(REG_SIM_ARM_EN, 16'(sim));
    write_reg(REG_ARM_TICKS, t);
    write_reg(REG_COMMAND_ENABLE, 16'(cen));
    write_reg(REG_STOP_CODE, 16'(sc));
    write_reg(REG_RESUME_CODE, 16'(rc));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait for every beat to be accepted and every result to arrive
  task automatic wait_drained();
    while (!(pend_items.size() == 0 && in_acc == in_put && expected_results.size() == 0))
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // directed, reset settings: broken hit run, then three hits stop
    push_item(OP_FRAME, 1'b1, 1'b0, 1'b1);
    push_item(OP_FRAME, 1'b1, 1'b1, 1'b1);
    push_item(OP_FRAME, 1'b0, 1'b0, 1'b1);
    push_item(OP_FRAME, 1'b1, 1'b0, 1'b1);
    push_item(OP_FRAME, 1'b1, 1'b0, 1'b1);
    push_item(OP_FRAME, 1'b1, 1'b0, 1'b1);
    // in arm: frame, tick outside simulate mode, done flag low, unused op
    push_item(OP_FRAME, 1'b1, 1'b1, 1'b1);
    push_item(OP_TICK, 1'b1, 1'b1, 1'b1);
    push_item(OP_ARM_DONE, 1'b1, 1'b0, 1'b1);
    push_item(OP_RESERVED, 1'b1, 1'b1, 1'b1);
    push_item(OP_RESERVED, 1'b0, 1'b0, 1'b1);
    push_item(OP_ARM_DONE, 1'b0, 1'b1, 1'b1);
    // done again with the arm phase over
    push_item(OP_ARM_DONE, 1'b1, 1'b1, 1'b1);
    // cooldown: broken miss run, then a full one re-arms
    repeat (4) push_item(OP_FRAME, 1'b0, 1'b1, 1'b1);
    push_item(OP_FRAME, 1'b1, 1'b0, 1'b1);
    repeat (5) push_item(OP_FRAME, 1'b0, 1'b0, 1'b1);
    push_item(OP_FRAME, 1'b1, 1'b0, 1'b1);
    wait_drained();

    // minimum thresholds, zero-length countdown, extreme codes
    apply_settings(8'd1, 8'd1, 1'b1, 16'd0, 1'b1, 8'hFF, 8'h00);
    gen_segment(120);
    wait_drained();

    // release below hold, short countdown, random codes
    apply_settings(8'd4, 8'd2, 1'b1, 16'd3, 1'b1, 8'($urandom), 8'($urandom));
    gen_segment(130);
    wait_drained();

    // maximum thresholds and duration, commands off
    apply_settings(8'd255, 8'd255, 1'b0, 16'hFFFF, 1'b0, 8'h00, 8'hFF);
    gen_segment(540);
    wait_drained();

    // lowered bounds over saturated counters, long countdown ended by done
    apply_settings(8'd2, 8'd7, 1'b1, 16'hFFFF, 1'b1, 8'($urandom), 8'($urandom));
    gen_segment(160);
    wait_drained();

    $display("Covered %0d input beats and %0d result beats over five register settings",
             in_acc, out_cnt);
    $display("Sequencer issued %0d stops and %0d resumes", stops_seen, resumes_seen);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
